[design/adpcm_block_decoder_2nd_order_defines.svh]
// ----------------------------------------------------------------------------
// ADPCM block decoder assertion macros
// Shared property forms for the decoder checks, clocked on clk_i, reset rst_ni.
// ----------------------------------------------------------------------------
`ifndef ADPCM_BLOCK_DECODER_2ND_ORDER_DEFINES_SVH
`define ADPCM_BLOCK_DECODER_2ND_ORDER_DEFINES_SVH

// Same-cycle implication.
`define ADBD_ASSERT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ADBD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/adbd_pkg.sv]
// ----------------------------------------------------------------------------
// ADPCM block decoder package
// Shared types, register indexes and queue sizing for the decoder.
// ----------------------------------------------------------------------------
package adbd_pkg;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_COEF_ONE      = 3'd0;
  localparam logic [2:0] REG_COEF_TWO      = 3'd1;
  localparam logic [2:0] REG_BLOCK_BYTES   = 3'd2;
  localparam logic [2:0] REG_CHANNEL_COUNT = 3'd3;
  localparam logic [2:0] REG_TOTAL_FRAMES  = 3'd4;

  // Command queue sizing
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [12:0]        coef_one;
    logic signed [12:0] coef_two;
    logic [7:0]         block_bytes;
    logic [1:0]         channel_count;
    logic [31:0]        total_frames;
  } adbd_cfg_t;

  // One classified input item
  typedef struct packed {
    logic        restart;
    logic        is_data;
    logic [7:0]  data;
    logic [15:0] scale;
    logic        ch;
    logic [1:0]  emit;   // bit k: nibble k is emitted (0 = high nibble)
    logic [1:0]  done;   // bit k: nibble k reaches the frame count
  } adbd_cmd_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } adbd_q_stat_t;

  typedef struct packed {
    logic idle;
    logic acc;
  } adbd_bk_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_ACC
  } adbd_bk_state_e;

endpackage

[design/adpcm_block_decoder_2nd_order.sv]
// ----------------------------------------------------------------------------
// Second-order 4-bit block ADPCM decoder
// Byte stream in, clamped 16-bit PCM samples out, APB register port.
// ----------------------------------------------------------------------------
// Feed stream bytes on s_axis (tdata = byte, tuser = restart). Each block opens
// with a big-endian 16-bit scale; the other bytes carry two nibbles, high first.
// Samples leave on m_axis: tdata = sample, tuser = {stream_done, channel_index},
// tlast marks the final sample produced by one input byte.
// Scale bytes are taken by the back end and produce nothing. Each nibble of a
// data byte passes through two back-end states, multiply, then accumulate and
// clamp, high nibble first; the history dependency between the two nibbles
// keeps them in sequence, and the next byte is taken only as the second nibble
// finishes. Each sample is registered at the output.
// A 4-entry queue sits between the byte tracker and the predictor, so input
// is taken while results wait; when the receiver stalls the output register
// holds, the predictor stops, the queue fills and s_axis_tready drops.
// Reset clears history, position, frame count and loads register defaults
// (coefficients 0, 18 bytes per block, 1 channel, 1 frame). Write registers
// only while the block is idle.
// ----------------------------------------------------------------------------
`include "adpcm_block_decoder_2nd_order_defines.svh"

module adpcm_block_decoder_2nd_order (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Byte input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_axis_tuser,   // [0] restart
  // Sample output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] sample
  output logic [1:0]  m_axis_tuser,   // [0] channel_index, [1] stream_done
  output logic        m_axis_tlast    // last_of_item
);
  import adbd_pkg::*;

  adbd_cfg_t     cfg_q;
  adbd_cmd_t     f_cmd, q_cmd;
  adbd_q_stat_t  q_stat;
  adbd_bk_stat_t bk_stat;
  logic          f_push, bk_pop, wr_en;
  logic [15:0]   bk_sample;
  logic          bk_ch, bk_done;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coef_one      <= '0;
      cfg_q.coef_two      <= '0;
      cfg_q.block_bytes   <= 8'd18;
      cfg_q.channel_count <= 2'd1;
      cfg_q.total_frames  <= 32'd1;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        REG_COEF_ONE:      cfg_q.coef_one      <= pwdata[12:0];
        REG_COEF_TWO:      cfg_q.coef_two      <= pwdata[12:0];
        REG_BLOCK_BYTES:   cfg_q.block_bytes   <= pwdata[7:0];
        REG_CHANNEL_COUNT: cfg_q.channel_count <= pwdata[1:0];
        REG_TOTAL_FRAMES:  cfg_q.total_frames  <= pwdata;
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (paddr[4:2])
      REG_COEF_ONE:      prdata = {19'd0, cfg_q.coef_one};
      REG_COEF_TWO:      prdata = {19'd0, cfg_q.coef_two};
      REG_BLOCK_BYTES:   prdata = {24'd0, cfg_q.block_bytes};
      REG_CHANNEL_COUNT: prdata = {30'd0, cfg_q.channel_count};
      REG_TOTAL_FRAMES:  prdata = cfg_q.total_frames;
      default:           prdata = '0;
    endcase
  end

  adbd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .data_i    (s_axis_tdata),
    .restart_i (s_axis_tuser[0]),
    .q_full_i  (q_stat.full),
    .push_o    (f_push),
    .cmd_o     (f_cmd)
  );

  adbd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (f_push),
    .cmd_i  (f_cmd),
    .pop_i  (bk_pop),
    .cmd_o  (q_cmd),
    .stat_o (q_stat)
  );

  adbd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_empty_i (q_stat.empty),
    .cmd_i     (q_cmd),
    .pop_o     (bk_pop),
    .stat_o    (bk_stat),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .sample_o  (bk_sample),
    .ch_o      (bk_ch),
    .last_o    (m_axis_tlast),
    .done_o    (bk_done)
  );

  assign m_axis_tdata = bk_sample;
  assign m_axis_tuser = {bk_done, bk_ch};

  // Input stalls only on a full queue
  `ADBD_ASSERT_HOLDS(a_stall_full, !s_axis_tready, q_stat.count == QCNT_W'(QDEPTH), "input stalled with queue space")
  // An idle predictor never leaves a queued item waiting
  `ADBD_ASSERT_HOLDS(a_idle_pops, !q_stat.empty && bk_stat.idle, bk_pop, "idle back end did not pop")
  // A new sample only follows an accumulate cycle
  `ADBD_ASSERT_NEXT(a_idle_no_out, bk_stat.idle, !$rose(m_axis_tvalid), "sample raised without accumulate")

endmodule

[design/adbd_front.sv]
// ----------------------------------------------------------------------------
// ADPCM block decoder front end
// Tracks block position, scale, channel and frame count; classifies each item.
// ----------------------------------------------------------------------------
module adbd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  adbd_pkg::adbd_cfg_t cfg_i,
  input  logic               s_valid_i,
  output logic               s_ready_o,
  input  logic [7:0]         data_i,
  input  logic               restart_i,
  input  logic               q_full_i,
  output logic               push_o,
  output adbd_pkg::adbd_cmd_t cmd_o
);
  import adbd_pkg::*;

  logic [7:0]  pos_q, pos_d;
  logic [15:0] scale_q, scale_d;
  logic        cur_q, cur_d;
  logic [31:0] fc_q, fc_d;

  logic        accept;
  logic [7:0]  pos, eb_raw, eb;
  logic [15:0] scale;
  logic        cur, nch_two, end_blk;
  logic [31:0] fc;
  logic [32:0] idx0, idx1, idx2, tf_x, fsum;

  assign s_ready_o = !q_full_i;
  assign accept    = s_valid_i && !q_full_i;
  assign push_o    = accept;

  // Apply restart, then derive block geometry
  always_comb begin
    pos     = restart_i ? 8'd0  : pos_q;
    scale   = restart_i ? 16'd0 : scale_q;
    fc      = restart_i ? 32'd0 : fc_q;
    nch_two = (cfg_i.channel_count >= 2'd2);
    cur     = (restart_i || !nch_two) ? 1'b0 : cur_q;
    eb_raw  = {cfg_i.block_bytes[7:1], 1'b0};
    eb      = (eb_raw < 8'd4) ? 8'd4 : eb_raw;
    end_blk = ({1'b0, pos} + 9'd1) >= {1'b0, eb};
  end

  // Frame index of both nibbles against the frame count
  always_comb begin
    idx0 = {1'b0, fc} + 33'({pos - 8'd2, 1'b0});
    idx1 = idx0 + 33'd1;
    idx2 = idx0 + 33'd2;
    tf_x = {1'b0, cfg_i.total_frames};
    fsum = {1'b0, fc} + 33'({eb - 8'd2, 1'b0});
  end

  // Build the command
  always_comb begin
    cmd_o.restart = restart_i;
    cmd_o.is_data = (pos >= 8'd2);
    cmd_o.data    = data_i;
    cmd_o.scale   = scale;
    cmd_o.ch      = cur;
    cmd_o.emit    = {idx1 < tf_x, idx0 < tf_x};
    cmd_o.done    = {idx2 == tf_x, idx1 == tf_x};
  end

  // Advance position, scale, channel and frame count
  always_comb begin
    scale_d = scale;
    if (pos == 8'd0) begin
      scale_d = {data_i, scale[7:0]};
    end else if (pos == 8'd1) begin
      scale_d = {scale[15:8], data_i};
    end
    pos_d = pos + 8'd1;
    cur_d = cur;
    fc_d  = fc;
    if (end_blk) begin
      pos_d = 8'd0;
      if (cur || !nch_two) begin
        cur_d = 1'b0;
        fc_d  = fsum[32] ? 32'hffff_ffff : fsum[31:0];
      end else begin
        cur_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      scale_q <= '0;
      cur_q   <= 1'b0;
      fc_q    <= '0;
    end else if (accept) begin
      pos_q   <= pos_d;
      scale_q <= scale_d;
      cur_q   <= cur_d;
      fc_q    <= fc_d;
    end
  end

endmodule

[design/adbd_fifo.sv]
// ----------------------------------------------------------------------------
// ADPCM block decoder command queue
// Small FIFO of classified items between the front and back ends.
// ----------------------------------------------------------------------------
module adbd_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  adbd_pkg::adbd_cmd_t    cmd_i,
  input  logic                   pop_i,
  output adbd_pkg::adbd_cmd_t    cmd_o,
  output adbd_pkg::adbd_q_stat_t stat_o
);
  import adbd_pkg::*;

  adbd_cmd_t         mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;

  assign cmd_o        = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == QCNT_W'(QDEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.count = cnt_q;

  // Store pushed items
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  // Move pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

endmodule

[design/adbd_back.sv]
// ----------------------------------------------------------------------------
// ADPCM block decoder back end
// Runs the second-order predictor per nibble and holds the output register.
// ----------------------------------------------------------------------------
module adbd_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  adbd_pkg::adbd_cfg_t     cfg_i,
  input  logic                    q_empty_i,
  input  adbd_pkg::adbd_cmd_t     cmd_i,
  output logic                    pop_o,
  output adbd_pkg::adbd_bk_stat_t stat_o,
  output logic                    m_valid_o,
  input  logic                    m_ready_i,
  output logic [15:0]             sample_o,
  output logic                    ch_o,
  output logic                    last_o,
  output logic                    done_o
);
  import adbd_pkg::*;

  adbd_bk_state_e state_q, state_d;
  adbd_cmd_t      cmd_q;
  logic           sel_q;

  logic signed [29:0] p1_q;
  logic signed [28:0] p2_q;
  logic signed [19:0] ns_q;
  logic signed [15:0] h1_q [2];
  logic signed [15:0] h2_q [2];

  logic               out_valid_q, out_ch_q, out_last_q, out_done_q;
  logic [15:0]        out_sample_q;

  logic signed [3:0]  nib;
  logic signed [30:0] psum;
  logic signed [20:0] vsum;
  logic signed [15:0] vclamp;
  logic               emit_cur, out_free, advance, finish, take;

  // Datapath terms
  always_comb begin
    nib      = sel_q ? cmd_q.data[3:0] : cmd_q.data[7:4];
    psum     = {p1_q[29], p1_q} + {{2{p2_q[28]}}, p2_q};
    vsum     = {ns_q[19], ns_q} + {{2{psum[30]}}, psum[30:12]};
    if (vsum > 21'sd32767) begin
      vclamp = 16'sh7fff;
    end else if (vsum < -21'sd32768) begin
      vclamp = 16'sh8000;
    end else begin
      vclamp = vsum[15:0];
    end
    emit_cur = cmd_q.emit[sel_q];
    out_free = !out_valid_q || m_ready_i;
    advance  = (state_q == BK_ACC) && (!emit_cur || out_free);
    finish   = advance && sel_q;
    take     = !q_empty_i && ((state_q == BK_IDLE) || finish);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    if (take) begin
      state_d = cmd_i.is_data ? BK_MUL : BK_IDLE;
    end else begin
      unique case (state_q)
        BK_IDLE: state_d = BK_IDLE;
        BK_MUL:  state_d = BK_ACC;
        BK_ACC:  state_d = advance ? (sel_q ? BK_IDLE : BK_MUL) : BK_ACC;
        default: state_d = BK_IDLE;
      endcase
    end
  end

  // Control outputs
  always_comb begin
    pop_o       = take;
    stat_o.idle = (state_q == BK_IDLE);
    stat_o.acc  = (state_q == BK_ACC);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      sel_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (take) begin
        sel_q <= 1'b0;
      end else if (advance && !sel_q) begin
        sel_q <= 1'b1;
      end
    end
  end

  // Latch command; form products for the current nibble
  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q <= cmd_i;
    end
    if (state_q == BK_MUL) begin
      p1_q <= $signed({1'b0, cfg_i.coef_one}) * h1_q[cmd_q.ch];
      p2_q <= cfg_i.coef_two * h2_q[cmd_q.ch];
      ns_q <= nib * $signed(cmd_q.scale);
    end
  end

  // Shift history; restart clears it as the restarting item is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h1_q <= '{default: '0};
      h2_q <= '{default: '0};
    end else if (take && cmd_i.restart) begin
      h1_q <= '{default: '0};
      h2_q <= '{default: '0};
    end else if (advance) begin
      h2_q[cmd_q.ch] <= h1_q[cmd_q.ch];
      h1_q[cmd_q.ch] <= vclamp;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && emit_cur) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit_cur) begin
      out_sample_q <= vclamp;
      out_ch_q     <= cmd_q.ch;
      out_last_q   <= sel_q || !cmd_q.emit[1];
      out_done_q   <= cmd_q.done[sel_q];
    end
  end

  assign m_valid_o = out_valid_q;
  assign sample_o  = out_sample_q;
  assign ch_o      = out_ch_q;
  assign last_o    = out_last_q;
  assign done_o    = out_done_q;

endmodule
